FILE: rtl/best_fit_partition_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit partition allocator
// Clocked concurrent checks with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BFPA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// trigger implies consequence in the next cycle
`define BFPA_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants of the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

   localparam int PART_COUNT_DEF = 16;
   localparam int SIZE_BITS_DEF  = 10;

   localparam int PI_W   = 4;   // partition_index / granted_index field
   localparam int SV_W   = 10;  // size_value field
   localparam int OWN_W  = 4;   // requester_id / granted_owner field
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_ALLOC = 1'b1
   } cmd_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan;
      logic grant;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic limit_zero;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/bfpa_ram.sv
// ----------------------------------------------------------------------------
// bfpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bfpa_ctrl.sv
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer: accepts a beat, runs the table scan and issues the grant.
// ----------------------------------------------------------------------------
module bfpa_ctrl
   import bfpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_GRANT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.limit_zero ? ST_GRANT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_GRANT;
         end
         ST_GRANT: begin
            if (status.rsp_free) begin
               cmd.grant = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/bfpa_datapath.sv
// ----------------------------------------------------------------------------
// bfpa_datapath
// Partition table, best-fit tracking, config register and result register.
// ----------------------------------------------------------------------------
module bfpa_datapath
   import bfpa_pkg::*;
#(
   parameter int PART_COUNT = PART_COUNT_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   input  logic [PI_W-1:0]   req_partition_index,
   input  logic [SV_W-1:0]   req_size_value,
   input  logic [OWN_W-1:0]  req_requester_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [PI_W-1:0]   rsp_granted_index,
   output logic [OWN_W-1:0]  rsp_granted_owner,
   input  ctl_cmd_type       cmd,
   output dp_status_type     status
);

   localparam int IDX_W = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;
   localparam int LIM_W = IDX_W + 1;

   logic [CFG_W-1:0]          cfg_ff;
   logic [31:0]               cfg_wide, lim_wide;
   logic [LIM_W-1:0]          limit;

   logic [SIZE_BITS-1:0]      req_size_ff;
   logic [OWN_W-1:0]          req_owner_ff;
   logic [IDX_W-1:0]          addr_ff;
   logic [LIM_W-1:0]          addr_next;

   logic [PART_COUNT-1:0]     taken_ff;
   logic                      cmp_vld_ff, cmp_taken_ff;
   logic [IDX_W-1:0]          cmp_idx_ff;
   logic [SIZE_BITS-1:0]      rd_size;

   logic                      have_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [SIZE_BITS-1:0]      best_size_ff;
   logic                      better;

   logic                      rsp_valid_ff, rsp_found_ff;
   logic [PI_W-1:0]           rsp_index_ff;
   logic [OWN_W-1:0]          rsp_owner_ff;

   logic [IDX_W+PI_W-1:0]     load_idx_ext;
   logic [IDX_W-1:0]          load_addr;
   logic                      load_in_range;
   logic [SIZE_BITS+SV_W-1:0] size_ext;
   logic [SIZE_BITS-1:0]      size_in;
   logic [IDX_W+PI_W-1:0]     best_idx_ext;

   assign cfg_wide = {{(32 - CFG_W){1'b0}}, cfg_ff};
   assign lim_wide = (cfg_wide > 32'(PART_COUNT)) ? 32'(PART_COUNT) : cfg_wide;
   assign limit    = lim_wide[LIM_W-1:0];

   assign load_idx_ext  = {{IDX_W{1'b0}}, req_partition_index};
   assign load_addr     = load_idx_ext[IDX_W-1:0];
   assign load_in_range = (32'(req_partition_index) < 32'(PART_COUNT));
   assign size_ext      = {{SIZE_BITS{1'b0}}, req_size_value};
   assign size_in       = size_ext[SIZE_BITS-1:0];
   assign best_idx_ext  = {{PI_W{1'b0}}, best_idx_ff};

   assign addr_next = {1'b0, addr_ff} + 1'b1;

   assign status.scan_last  = (addr_next == limit);
   assign status.limit_zero = (limit == '0);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   bfpa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (PART_COUNT)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (cmd.load && load_in_range),
      .wr_addr (load_addr),
      .wr_data (size_in),
      .rd_addr (addr_ff),
      .rd_data (rd_size)
   );

   assign better = cmp_vld_ff && !cmp_taken_ff && (rd_size >= req_size_ff) &&
                   (!have_ff || (rd_size < best_size_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         taken_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cmd.load && load_in_range) begin
            taken_ff[load_addr] <= 1'b0;
         end
         cmp_vld_ff <= cmd.scan;
         if (cmd.start) begin
            have_ff <= 1'b0;
         end else if (better) begin
            have_ff <= 1'b1;
         end
         if (cmd.grant) begin
            rsp_valid_ff <= 1'b1;
            if (have_ff) begin
               taken_ff[best_idx_ff] <= 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_size_ff  <= size_in;
         req_owner_ff <= req_requester_id;
         addr_ff      <= '0;
      end else if (cmd.scan) begin
         addr_ff <= addr_next[IDX_W-1:0];
      end
      cmp_idx_ff   <= addr_ff;
      cmp_taken_ff <= taken_ff[addr_ff];
      if (better) begin
         best_idx_ff  <= cmp_idx_ff;
         best_size_ff <= rd_size;
      end
      if (cmd.grant) begin
         rsp_found_ff <= have_ff;
         rsp_index_ff <= have_ff ? best_idx_ext[PI_W-1:0] : '0;
         rsp_owner_ff <= have_ff ? req_owner_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_granted_owner = rsp_owner_ff;

endmodule

FILE: rtl/best_fit_partition_allocator.sv
// Load beat: the table write lands at the accept edge; the sequencer stays idle.
// Allocate beat: the size RAM is scanned over L entries, one entry per cycle, then
// the wait and grant states follow and the result is registered in the output register;
// L = min(partitions_in_use, PART_COUNT), and when L = 0 scan and wait are skipped.
// Next beat taken in idle after the grant; it waits while the output register is stalled.
// Synchronous active-high reset clears all taken flags and sets partitions_in_use to 16.
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Best-fit fixed-partition allocator: sequencer plus table datapath.
// ----------------------------------------------------------------------------
`include "best_fit_partition_allocator_assert.svh"

module best_fit_partition_allocator
   import bfpa_pkg::*;
#(
   parameter int PART_COUNT = PART_COUNT_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [PI_W-1:0]  req_partition_index,
   input  logic [SV_W-1:0]  req_size_value,
   input  logic [OWN_W-1:0] req_requester_id,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_found,
   output logic [PI_W-1:0]  rsp_granted_index,
   output logic [OWN_W-1:0] rsp_granted_owner
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   bfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfpa_datapath #(
      .PART_COUNT (PART_COUNT),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_partition_index (req_partition_index),
      .req_size_value      (req_size_value),
      .req_requester_id    (req_requester_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_granted_owner   (rsp_granted_owner),
      .cmd                 (cmd),
      .status              (status)
   );

   `BFPA_ASSERT(a_cmd_exclusive, clock, reset, $onehot0(cmd), "controller commands overlap")
   `BFPA_ASSERT(a_grant_free, clock, reset, !cmd.grant || status.rsp_free, "result reg busy")
   `BFPA_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start, req_stall, "no stall after start")
   `BFPA_ASSERT_NEXT(a_grant_valid, clock, reset, cmd.grant, rsp_valid, "grant without valid")

endmodule
